// ===== sv/tsch_pkg.sv =====
// Shared types, constants and helpers for the issue/wakeup scheduler.
// No dependencies.
package tsch_pkg;

  localparam int N_ENT = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int REG_N = 32;
  localparam int REG_W = 5;
  localparam int LAT_W = 8;

  localparam logic       CMD_ISSUE = 1'b0;
  localparam logic       CMD_TICK  = 1'b1;
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DIV  = 2'd1;
  localparam logic [1:0] KIND_MEM  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [2:0] CFG_UNIFIED_MODE = 3'd0;
  localparam logic [2:0] CFG_UNIFIED_ENT  = 3'd1;
  localparam logic [2:0] CFG_ADD_ENT      = 3'd2;
  localparam logic [2:0] CFG_DIV_ENT      = 3'd3;
  localparam logic [2:0] CFG_MEM_ENT      = 3'd4;
  localparam logic [2:0] CFG_ADD_LAT      = 3'd5;
  localparam logic [2:0] CFG_DIV_LAT      = 3'd6;
  localparam logic [2:0] CFG_MEM_LAT      = 3'd7;

  typedef struct packed {
    logic       command;
    logic [1:0] op_kind;
    logic [4:0] dest_reg;
    logic [4:0] first_src_reg;
    logic       first_src_used;
    logic [4:0] second_src_reg;
    logic       second_src_used;
  } in_item_t;

  typedef struct packed {
    logic        issued;
    logic        stalled;
    logic [4:0]  completed_count;
    logic [1:0]  fired_count;
    logic [4:0]  active_add;
    logic [4:0]  active_div;
    logic [4:0]  active_mem;
    logic        all_drained;
    logic [31:0] cycle_now;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_NOP    = 2'd0,
    ST_WRITE  = 2'd1,
    ST_RETIRE = 2'd2,
    ST_FIRE   = 2'd3
  } st_op_t;

  typedef struct packed {
    st_op_t           op;
    logic [IDX_W-1:0] idx;
    logic             fire_go;
    logic [1:0]       kind;
    logic [REG_W-1:0] dest;
    logic [1:0]       wait_bits;
    logic [IDX_W-1:0] tag0;
    logic [IDX_W-1:0] tag1;
  } st_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             started;
    logic             ready;
    logic             retire;
    logic [1:0]       kind;
    logic [REG_W-1:0] dest;
  } st_stat_t;

  function automatic logic [CNT_W-1:0] clamp_ent(input logic [CNT_W:0] v);
    clamp_ent = (v > (CNT_W+1)'(N_ENT)) ? CNT_W'(N_ENT) : v[CNT_W-1:0];
  endfunction

  function automatic logic [LAT_W-1:0] lat_of(input logic [1:0] kind,
                                              input logic [LAT_W-1:0] la,
                                              input logic [LAT_W-1:0] ld,
                                              input logic [LAT_W-1:0] lm);
    logic [LAT_W-1:0] l;
    case (kind)
      KIND_ADD: l = la;
      KIND_DIV: l = ld;
      default:  l = lm;
    endcase
    lat_of = (l == '0) ? LAT_W'(1) : l;
  endfunction

endpackage

// ===== sv/tsch_alias.sv =====
// Register alias table: tag per architectural register plus a renamed bit.
// Depends on tsch_pkg.
module tsch_alias import tsch_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [REG_W-1:0] rd_addr,
  output logic             rd_named,
  output logic [IDX_W-1:0] rd_tag,
  input  logic             wr_en,
  input  logic [REG_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] wr_tag,
  input  logic             clr_en,
  input  logic [REG_W-1:0] clr_addr
);

  logic [REG_N-1:0] named_r;
  logic [IDX_W-1:0] tag_r [REG_N];

  assign rd_named = named_r[rd_addr];
  assign rd_tag   = tag_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      named_r <= '0;
    end else if (wr_en) begin
      named_r[wr_addr] <= 1'b1;
    end else if (clr_en) begin
      named_r[clr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_r[wr_addr] <= wr_tag;
    end
  end

endmodule

// ===== sv/tsch_station.sv =====
// Reservation station entries and the per-entry step unit (write, retire, fire).
// Depends on tsch_pkg.
module tsch_station import tsch_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  st_ctl_t          ctl,
  input  logic [LAT_W-1:0] add_lat,
  input  logic [LAT_W-1:0] div_lat,
  input  logic [LAT_W-1:0] mem_lat,
  output st_stat_t         stat
);

  logic [N_ENT-1:0] valid_r;
  logic [N_ENT-1:0] started_r;
  logic [1:0]       kind_r [N_ENT];
  logic [REG_W-1:0] dest_r [N_ENT];
  logic [1:0]       wait_r [N_ENT];
  logic [IDX_W-1:0] tag0_r [N_ENT];
  logic [IDX_W-1:0] tag1_r [N_ENT];
  logic [LAT_W-1:0] rem_r  [N_ENT];

  assign stat.valid   = valid_r[ctl.idx];
  assign stat.started = started_r[ctl.idx];
  assign stat.kind    = kind_r[ctl.idx];
  assign stat.dest    = dest_r[ctl.idx];
  assign stat.ready   = valid_r[ctl.idx] && !started_r[ctl.idx] && (wait_r[ctl.idx] == 2'b00);
  assign stat.retire  = valid_r[ctl.idx] && started_r[ctl.idx] &&
                        (rem_r[ctl.idx] == LAT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      started_r <= '0;
    end else begin
      case (ctl.op)
        ST_WRITE: begin
          valid_r[ctl.idx]   <= 1'b1;
          started_r[ctl.idx] <= 1'b0;
        end
        ST_RETIRE: begin
          if (stat.retire) begin
            valid_r[ctl.idx]   <= 1'b0;
            started_r[ctl.idx] <= 1'b0;
          end
        end
        ST_FIRE: begin
          if (ctl.fire_go) begin
            started_r[ctl.idx] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload: no reset, only read while valid
  always_ff @(posedge clk) begin
    case (ctl.op)
      ST_WRITE: begin
        kind_r[ctl.idx] <= ctl.kind;
        dest_r[ctl.idx] <= ctl.dest;
        wait_r[ctl.idx] <= ctl.wait_bits;
        tag0_r[ctl.idx] <= ctl.tag0;
        tag1_r[ctl.idx] <= ctl.tag1;
      end
      ST_RETIRE: begin
        if (stat.retire) begin
          // broadcast the retiring tag to every waiting source
          for (int j = 0; j < N_ENT; j++) begin
            wait_r[j] <= wait_r[j] & ~{valid_r[j] && (tag1_r[j] == ctl.idx),
                                       valid_r[j] && (tag0_r[j] == ctl.idx)};
          end
        end else if (valid_r[ctl.idx] && started_r[ctl.idx]) begin
          rem_r[ctl.idx] <= rem_r[ctl.idx] - LAT_W'(1);
        end
      end
      ST_FIRE: begin
        if (ctl.fire_go) begin
          rem_r[ctl.idx] <= lat_of(kind_r[ctl.idx], add_lat, div_lat, mem_lat);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/tomasulo_issue_wakeup_scheduler.sv =====
// Top level: sequencer, configuration registers and result register.
// Depends on tsch_pkg, tsch_alias, tsch_station.
//
// One item is handled at a time by a sequencer that walks the 16 station
// entries through a single entry step unit. An issue is latched, scans up to
// 16 entries from the bottom of its range for a free one, renames both
// sources and writes the entry, then makes a counting pass over all entries
// and loads the result. A refused issue scans its whole range and skips the
// rename and write states. An issue of the unknown kind goes straight to the
// counting pass. A tick makes a retire and wakeup pass and then a fire and
// count pass before its result is loaded. A result then sits in the output
// register; the next item is taken while it waits. in_stall is high while
// an item is being worked. The alias table has one read port, shared by
// source renaming and the retirement check.
module tomasulo_issue_wakeup_scheduler import tsch_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_SRC1   = 8'b0000_0100,
    S_SRC2   = 8'b0000_1000,
    S_WRITE  = 8'b0001_0000,
    S_RETIRE = 8'b0010_0000,
    S_FIRE   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic             unified_mode_r;
  logic [CNT_W-1:0] unified_ent_r, add_ent_r, div_ent_r, mem_ent_r;
  logic [LAT_W-1:0] add_lat_r, div_lat_r, mem_lat_r;

  // item work registers
  in_item_t         item_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [1:0]       wait_r, wait_nxt;
  logic [IDX_W-1:0] tag0_r, tag0_nxt;
  logic [IDX_W-1:0] tag1_r, tag1_nxt;
  logic [2:0]       fkind_r, fkind_nxt;
  logic             issued_r, issued_nxt;
  logic             stalled_r, stalled_nxt;
  logic [CNT_W-1:0] compl_r, compl_nxt;
  logic [1:0]       fired_r, fired_nxt;
  logic [CNT_W-1:0] act_add_r, act_add_nxt;
  logic [CNT_W-1:0] act_div_r, act_div_nxt;
  logic [CNT_W-1:0] act_mem_r, act_mem_nxt;
  logic             anyv_r, anyv_nxt;
  logic [31:0]      cycle_r, cycle_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  // alias table hookup
  logic [REG_W-1:0] al_rd_addr;
  logic             al_named;
  logic [IDX_W-1:0] al_tag;
  logic             al_wr_en, al_clr_en;

  st_ctl_t          st_ctl;
  st_stat_t         st_stat;

  logic             in_xfer, out_xfer, cfg_wr;
  logic             last_ent, fire_go, counted_started;
  logic [2:0]       kmask;
  logic [CNT_W-1:0] a_end, d_end, m_end;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_xfer  = out_valid_r && !out_stall;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign last_ent  = (idx_r[IDX_W-1:0] == IDX_W'(N_ENT-1));

  // per-unit ranges, clamped to station size
  assign a_end = clamp_ent({1'b0, add_ent_r});
  assign d_end = clamp_ent({1'b0, a_end} + {1'b0, div_ent_r});
  assign m_end = clamp_ent({1'b0, d_end} + {1'b0, mem_ent_r});

  always_comb begin
    case (st_stat.kind)
      KIND_ADD: kmask = 3'b001;
      KIND_DIV: kmask = 3'b010;
      KIND_MEM: kmask = 3'b100;
      default:  kmask = 3'b000;
    endcase
  end

  // at most one fire per unit kind, lowest entry first
  assign fire_go = (state_r == S_FIRE) && (item_r.command == CMD_TICK) && st_stat.ready &&
                   (kmask != 3'b000) && ((fkind_r & kmask) == 3'b000);
  assign counted_started = st_stat.started || fire_go;

  assign al_rd_addr = (state_r == S_SRC1)   ? item_r.first_src_reg  :
                      (state_r == S_SRC2)   ? item_r.second_src_reg : st_stat.dest;
  assign al_wr_en   = (state_r == S_WRITE);
  // clear only if the alias still names the retiring entry
  assign al_clr_en  = (state_r == S_RETIRE) && st_stat.retire && al_named &&
                      (al_tag == idx_r[IDX_W-1:0]);

  always_comb begin
    st_ctl           = '0;
    st_ctl.op        = ST_NOP;
    st_ctl.idx       = idx_r[IDX_W-1:0];
    st_ctl.fire_go   = fire_go;
    st_ctl.kind      = item_r.op_kind;
    st_ctl.dest      = item_r.dest_reg;
    st_ctl.wait_bits = wait_r;
    st_ctl.tag0      = tag0_r;
    st_ctl.tag1      = tag1_r;
    case (state_r)
      S_WRITE: begin
        st_ctl.op  = ST_WRITE;
        st_ctl.idx = slot_r;
      end
      S_RETIRE: st_ctl.op = ST_RETIRE;
      S_FIRE:   st_ctl.op = ST_FIRE;
      default:  ;
    endcase
  end

  tsch_alias u_alias (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (al_rd_addr),
    .rd_named (al_named),
    .rd_tag   (al_tag),
    .wr_en    (al_wr_en),
    .wr_addr  (item_r.dest_reg),
    .wr_tag   (slot_r),
    .clr_en   (al_clr_en),
    .clr_addr (st_stat.dest)
  );

  tsch_station u_station (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (st_ctl),
    .add_lat (add_lat_r),
    .div_lat (div_lat_r),
    .mem_lat (mem_lat_r),
    .stat    (st_stat)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    hi_nxt        = hi_r;
    slot_nxt      = slot_r;
    wait_nxt      = wait_r;
    tag0_nxt      = tag0_r;
    tag1_nxt      = tag1_r;
    fkind_nxt     = fkind_r;
    issued_nxt    = issued_r;
    stalled_nxt   = stalled_r;
    compl_nxt     = compl_r;
    fired_nxt     = fired_r;
    act_add_nxt   = act_add_r;
    act_div_nxt   = act_div_r;
    act_mem_nxt   = act_mem_r;
    anyv_nxt      = anyv_r;
    cycle_nxt     = cycle_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          idx_nxt     = '0;
          fkind_nxt   = '0;
          issued_nxt  = 1'b0;
          stalled_nxt = 1'b0;
          compl_nxt   = '0;
          fired_nxt   = '0;
          act_add_nxt = '0;
          act_div_nxt = '0;
          act_mem_nxt = '0;
          anyv_nxt    = 1'b0;
          wait_nxt    = '0;
          tag0_nxt    = '0;
          tag1_nxt    = '0;
          if (in_data.command == CMD_TICK) begin
            cycle_nxt = cycle_r + 32'd1;
            state_nxt = S_RETIRE;
          end else if (in_data.op_kind == KIND_NONE) begin
            // unknown unit kind: ignored, just report counts
            state_nxt = S_FIRE;
          end else begin
            state_nxt = S_SCAN;
            if (unified_mode_r) begin
              hi_nxt = clamp_ent({1'b0, unified_ent_r});
            end else begin
              case (in_data.op_kind)
                KIND_ADD: hi_nxt = a_end;
                KIND_DIV: begin
                  idx_nxt = a_end;
                  hi_nxt  = d_end;
                end
                default: begin
                  idx_nxt = d_end;
                  hi_nxt  = m_end;
                end
              endcase
            end
          end
        end
      end
      S_SCAN: begin
        if (idx_r >= hi_r) begin
          stalled_nxt = 1'b1;
          idx_nxt     = '0;
          state_nxt   = S_FIRE;
        end else if (!st_stat.valid) begin
          slot_nxt  = idx_r[IDX_W-1:0];
          state_nxt = S_SRC1;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_SRC1: begin
        wait_nxt[0] = item_r.first_src_used && al_named;
        tag0_nxt    = (item_r.first_src_used && al_named) ? al_tag : '0;
        state_nxt   = S_SRC2;
      end
      S_SRC2: begin
        wait_nxt[1] = item_r.second_src_used && al_named;
        tag1_nxt    = (item_r.second_src_used && al_named) ? al_tag : '0;
        state_nxt   = S_WRITE;
      end
      S_WRITE: begin
        issued_nxt = 1'b1;
        idx_nxt    = '0;
        state_nxt  = S_FIRE;
      end
      S_RETIRE: begin
        if (st_stat.retire) begin
          compl_nxt = compl_r + CNT_W'(1);
        end
        idx_nxt = last_ent ? '0 : idx_r + CNT_W'(1);
        if (last_ent) begin
          state_nxt = S_FIRE;
        end
      end
      S_FIRE: begin
        // fire (ticks only) and count in the same walk
        if (fire_go) begin
          fkind_nxt = fkind_r | kmask;
          fired_nxt = fired_r + 2'd1;
        end
        if (st_stat.valid) begin
          anyv_nxt = 1'b1;
          if (counted_started) begin
            case (st_stat.kind)
              KIND_ADD: act_add_nxt = act_add_r + CNT_W'(1);
              KIND_DIV: act_div_nxt = act_div_r + CNT_W'(1);
              KIND_MEM: act_mem_nxt = act_mem_r + CNT_W'(1);
              default:  ;
            endcase
          end
        end
        idx_nxt = last_ent ? '0 : idx_r + CNT_W'(1);
        if (last_ent) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.issued          = issued_r;
          out_nxt.stalled         = stalled_r;
          out_nxt.completed_count = compl_r;
          out_nxt.fired_count     = fired_r;
          out_nxt.active_add      = act_add_r;
          out_nxt.active_div      = act_div_r;
          out_nxt.active_mem      = act_mem_r;
          out_nxt.all_drained     = !anyv_r;
          out_nxt.cycle_now       = cycle_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cycle_r     <= 32'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cycle_r     <= cycle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    idx_r     <= idx_nxt;
    hi_r      <= hi_nxt;
    slot_r    <= slot_nxt;
    wait_r    <= wait_nxt;
    tag0_r    <= tag0_nxt;
    tag1_r    <= tag1_nxt;
    fkind_r   <= fkind_nxt;
    issued_r  <= issued_nxt;
    stalled_r <= stalled_nxt;
    compl_r   <= compl_nxt;
    fired_r   <= fired_nxt;
    act_add_r <= act_add_nxt;
    act_div_r <= act_div_nxt;
    act_mem_r <= act_mem_nxt;
    anyv_r    <= anyv_nxt;
    out_r     <= out_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unified_mode_r <= 1'b1;
      unified_ent_r  <= CNT_W'(16);
      add_ent_r      <= CNT_W'(4);
      div_ent_r      <= CNT_W'(2);
      mem_ent_r      <= CNT_W'(1);
      add_lat_r      <= LAT_W'(2);
      div_lat_r      <= LAT_W'(15);
      mem_lat_r      <= LAT_W'(20);
    end else if (cfg_wr) begin
      case (paddr[4:2])
        CFG_UNIFIED_MODE: unified_mode_r <= pwdata[0];
        CFG_UNIFIED_ENT:  unified_ent_r  <= pwdata[CNT_W-1:0];
        CFG_ADD_ENT:      add_ent_r      <= pwdata[CNT_W-1:0];
        CFG_DIV_ENT:      div_ent_r      <= pwdata[CNT_W-1:0];
        CFG_MEM_ENT:      mem_ent_r      <= pwdata[CNT_W-1:0];
        CFG_ADD_LAT:      add_lat_r      <= pwdata[LAT_W-1:0];
        CFG_DIV_LAT:      div_lat_r      <= pwdata[LAT_W-1:0];
        CFG_MEM_LAT:      mem_lat_r      <= pwdata[LAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      CFG_UNIFIED_MODE: prdata = {31'd0, unified_mode_r};
      CFG_UNIFIED_ENT:  prdata = {27'd0, unified_ent_r};
      CFG_ADD_ENT:      prdata = {27'd0, add_ent_r};
      CFG_DIV_ENT:      prdata = {27'd0, div_ent_r};
      CFG_MEM_ENT:      prdata = {27'd0, mem_ent_r};
      CFG_ADD_LAT:      prdata = {24'd0, add_lat_r};
      CFG_DIV_LAT:      prdata = {24'd0, div_lat_r};
      CFG_MEM_LAT:      prdata = {24'd0, mem_lat_r};
      default:          prdata = 32'd0;
    endcase
  end

`ifndef SYNTH
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("scheduler not busy after input transfer");

  a_issue_xor_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.issued && out_data.stalled))
    else $error("result both issued and stalled");

  a_issue_no_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.issued || out_data.stalled)) |->
      (out_data.completed_count == '0 && out_data.fired_count == '0))
    else $error("issue result carries tick counts");

  a_retire_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RETIRE) |=> (state_r == S_RETIRE || state_r == S_FIRE))
    else $error("retire pass left early");
`endif

endmodule

// ===== test/tb_tomasulo_issue_wakeup_scheduler.sv =====
// Self-checking testbench for the issue/wakeup scheduler: random and directed issue/tick
// items checked against an in-bench scheduler predictor. Depends on tsch_pkg and
// tomasulo_issue_wakeup_scheduler.
module tb_tomasulo_issue_wakeup_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import tsch_pkg::*;

  localparam logic [1:0] KIND_BAD   = 2'd3;  // undefined unit kind, ignored by the block
  localparam int         IDLE_LIMIT = 4000;  // cycles without any transfer
  localparam int         LONG_HOLD  = 400;
  localparam int         SETTLE     = 60;    // longer than any single item

  // Scheduler predictor plus queue of expected results.
  class sched_scoreboard;
    bit               ent_valid[N_ENT];
    bit               ent_started[N_ENT];
    logic [1:0]       ent_kind[N_ENT];
    logic [4:0]       ent_dest[N_ENT];
    logic [1:0]       ent_wait[N_ENT];
    logic [3:0]       ent_tag0[N_ENT];
    logic [3:0]       ent_tag1[N_ENT];
    logic [7:0]       ent_left[N_ENT];
    bit               reg_renamed[REG_N];
    logic [3:0]       reg_tag[REG_N];
    logic [31:0]      cycle;
    bit               unified;
    int unsigned      uni_n, add_n, div_n, mem_n;
    logic [7:0]       lat[3];
    out_item_t        pending_results[$];
    int               mismatches;

    function new();
      foreach (ent_valid[i]) begin
        ent_valid[i] = 0;
        ent_started[i] = 0;
      end
      foreach (reg_renamed[r]) reg_renamed[r] = 0;
      cycle = 1;
      unified = 1;
      uni_n = 16; add_n = 4; div_n = 2; mem_n = 1;
      lat[0] = 2; lat[1] = 15; lat[2] = 20;
      mismatches = 0;
    endfunction

    function int unsigned clampn(int unsigned v);
      return v > N_ENT ? N_ENT : v;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        CFG_UNIFIED_MODE: unified = v[0];
        CFG_UNIFIED_ENT:  uni_n = v[4:0];
        CFG_ADD_ENT:      add_n = v[4:0];
        CFG_DIV_ENT:      div_n = v[4:0];
        CFG_MEM_ENT:      mem_n = v[4:0];
        CFG_ADD_LAT:      lat[0] = v[7:0];
        CFG_DIV_LAT:      lat[1] = v[7:0];
        default:          lat[2] = v[7:0];
      endcase
    endfunction

    // rename sources, claim the lowest free entry of the range
    function bit try_issue(in_item_t it);
      int unsigned lo, hi, a_end, d_end;
      int slot;
      if (unified) begin
        lo = 0;
        hi = clampn(uni_n);
      end else begin
        a_end = clampn(add_n);
        d_end = clampn(a_end + div_n);
        if (it.op_kind == KIND_ADD) begin
          lo = 0; hi = a_end;
        end else if (it.op_kind == KIND_DIV) begin
          lo = a_end; hi = d_end;
        end else begin
          lo = d_end; hi = clampn(d_end + mem_n);
        end
      end
      slot = -1;
      for (int i = lo; i < hi; i++)
        if (!ent_valid[i] && slot < 0) slot = i;
      if (slot < 0) return 0;
      ent_wait[slot] = 2'b00;
      ent_tag0[slot] = 0;
      ent_tag1[slot] = 0;
      if (it.first_src_used && reg_renamed[it.first_src_reg]) begin
        ent_wait[slot][0] = 1;
        ent_tag0[slot] = reg_tag[it.first_src_reg];
      end
      if (it.second_src_used && reg_renamed[it.second_src_reg]) begin
        ent_wait[slot][1] = 1;
        ent_tag1[slot] = reg_tag[it.second_src_reg];
      end
      ent_valid[slot] = 1;
      ent_started[slot] = 0;
      ent_kind[slot] = it.op_kind;
      ent_dest[slot] = it.dest_reg;
      ent_left[slot] = 0;
      reg_renamed[it.dest_reg] = 1;
      reg_tag[it.dest_reg] = slot[3:0];
      return 1;
    endfunction

    function out_item_t predict_step(in_item_t it);
      out_item_t r;
      int unsigned done_n, fire_n;
      int unsigned act[3];
      bit kind_busy[3];
      r = '0;
      done_n = 0; fire_n = 0;
      act = '{0, 0, 0};
      kind_busy = '{0, 0, 0};
      if (it.command == CMD_ISSUE) begin
        if (it.op_kind != KIND_BAD) begin
          r.issued = try_issue(it);
          r.stalled = !r.issued;
        end
      end else begin
        cycle++;
        for (int i = 0; i < N_ENT; i++) begin
          if (!ent_valid[i] || !ent_started[i]) continue;
          if (ent_left[i] > 0) ent_left[i]--;
          if (ent_left[i] == 0) begin
            // only clear the alias if it still names this entry
            if (reg_renamed[ent_dest[i]] && reg_tag[ent_dest[i]] == i)
              reg_renamed[ent_dest[i]] = 0;
            ent_valid[i] = 0;
            ent_started[i] = 0;
            for (int j = 0; j < N_ENT; j++) begin
              if (!ent_valid[j]) continue;
              if (ent_wait[j][0] && ent_tag0[j] == i) ent_wait[j][0] = 0;
              if (ent_wait[j][1] && ent_tag1[j] == i) ent_wait[j][1] = 0;
            end
            done_n++;
          end
        end
        for (int i = 0; i < N_ENT; i++) begin
          if (!ent_valid[i] || ent_started[i] || ent_wait[i] != 0 || ent_kind[i] > 2) continue;
          if (kind_busy[ent_kind[i]]) continue;
          kind_busy[ent_kind[i]] = 1;
          ent_started[i] = 1;
          ent_left[i] = lat[ent_kind[i]] == 0 ? 8'd1 : lat[ent_kind[i]];
          fire_n++;
        end
      end
      r.all_drained = 1;
      for (int i = 0; i < N_ENT; i++) begin
        if (!ent_valid[i]) continue;
        r.all_drained = 0;
        if (ent_started[i] && ent_kind[i] < 3) act[ent_kind[i]]++;
      end
      r.completed_count = done_n[4:0];
      r.fired_count = fire_n[1:0];
      r.active_add = act[0][4:0];
      r.active_div = act[1][4:0];
      r.active_mem = act[2][4:0];
      r.cycle_now = cycle;
      return r;
    endfunction

    function void note_item(in_item_t it);
      pending_results.push_back(predict_step(it));
    endfunction

    function void cmp(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, e, a);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $realtime, got);
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      cmp("issued", e.issued, got.issued);
      cmp("stalled", e.stalled, got.stalled);
      cmp("completed_count", e.completed_count, got.completed_count);
      cmp("fired_count", e.fired_count, got.fired_count);
      cmp("active_add", e.active_add, got.active_add);
      cmp("active_div", e.active_div, got.active_div);
      cmp("active_mem", e.active_mem, got.active_mem);
      cmp("all_drained", e.all_drained, got.all_drained);
      cmp("cycle_now", e.cycle_now, got.cycle_now);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1;
  out_item_t   out_data;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sched_scoreboard sched_sb = new();
  bit hold_req = 0;  // asks the result side for one long hold-off
  int idle_cycles = 0;

  tomasulo_issue_wakeup_scheduler u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial forever #5 clk = ~clk;

  // Watchdog: any stretch without a transfer on either channel that is too long ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL tomasulo_issue_wakeup_scheduler");
        $finish;
      end
    end
  end

  // Result side: random hold-off per transfer, one long one on request so the
  // block backs up and stalls its input.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      n = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (hold_req) begin
        hold_req = 0;
        n = LONG_HOLD;
      end
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      sched_sb.check_result(out_data);
    end
  end

  // Offer one item; valid stays high across back-to-back transfers.
  task automatic send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sched_sb.note_item(it);
  endtask

  // Lower valid and wait for every expected result plus the block's own time.
  task automatic drain();
    in_valid <= 0;
    while (sched_sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);  // pready always high: write lands here
    psel <= 0; penable <= 0; pwrite <= 0;
    sched_sb.write_reg(idx, v);
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
  endfunction

  // Random issue and tick items, mostly of a known kind, with a dense register pool so renames collide.
  function automatic in_item_t rand_item();
    in_item_t it;
    it.command = ($urandom_range(0, 99) < 48) ? CMD_TICK : CMD_ISSUE;
    it.op_kind = ($urandom_range(0, 19) == 0) ? KIND_BAD : 2'($urandom_range(0, 2));
    it.dest_reg = pick_reg();
    it.first_src_reg = pick_reg();
    it.first_src_used = $urandom_range(0, 3) != 0;
    it.second_src_reg = pick_reg();
    it.second_src_used = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t mk(logic cmd, logic [1:0] k, logic [4:0] d,
                                  logic [4:0] s1, logic u1, logic [4:0] s2, logic u2);
    in_item_t it;
    it.command = cmd; it.op_kind = k; it.dest_reg = d;
    it.first_src_reg = s1; it.first_src_used = u1;
    it.second_src_reg = s2; it.second_src_used = u2;
    return it;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_item(rand_item());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: register extremes, dependency chain, ignored kind, ticks.
    send_item(mk(CMD_ISSUE, KIND_ADD, 5'd31, 5'd31, 1'b1, 5'd0, 1'b0));
    send_item(mk(CMD_ISSUE, KIND_DIV, 5'd0, 5'd31, 1'b1, 5'd31, 1'b1));
    send_item(mk(CMD_ISSUE, KIND_MEM, 5'd31, 5'd0, 1'b1, 5'd31, 1'b1));
    send_item(mk(CMD_ISSUE, KIND_BAD, 5'd7, 5'd1, 1'b1, 5'd2, 1'b1));
    send_item(mk(CMD_ISSUE, KIND_ADD, 5'd31, 5'd0, 1'b0, 5'd0, 1'b1));
    repeat (8) send_item(mk(CMD_TICK, KIND_BAD, 5'd31, 5'd31, 1'b1, 5'd31, 1'b1));
    run_random(70);
    drain();

    // Single shared entry; a zero add latency is replaced by the smallest nonzero value.
    cfg_write(CFG_UNIFIED_ENT, 32'd1);
    cfg_write(CFG_ADD_LAT, 32'd0);
    cfg_write(CFG_DIV_LAT, 32'd1);
    cfg_write(CFG_MEM_LAT, 32'd1);
    send_item(mk(CMD_ISSUE, KIND_ADD, 5'd3, 5'd0, 1'b0, 5'd0, 1'b0));
    send_item(mk(CMD_ISSUE, KIND_DIV, 5'd4, 5'd3, 1'b1, 5'd0, 1'b0));  // full: stalls
    run_random(60);
    drain();

    // Per-unit split at defaults, with a long result hold-off to back up the block.
    cfg_write(CFG_UNIFIED_MODE, 32'd0);
    cfg_write(CFG_ADD_LAT, 32'd2);
    cfg_write(CFG_DIV_LAT, 32'd15);
    cfg_write(CFG_MEM_LAT, 32'd20);
    hold_req = 1;
    run_random(80);
    drain();

    // Empty add range, clamped divide and memory ranges, maximum latency.
    cfg_write(CFG_ADD_ENT, 32'd0);
    cfg_write(CFG_DIV_ENT, 32'd16);
    cfg_write(CFG_MEM_ENT, 32'd31);
    cfg_write(CFG_ADD_LAT, 32'd255);
    cfg_write(CFG_DIV_LAT, 32'd255);
    cfg_write(CFG_MEM_LAT, 32'd3);
    run_random(60);
    drain();

    // Whole station for add; divide and memory ranges past the end.
    cfg_write(CFG_ADD_ENT, 32'd31);
    cfg_write(CFG_DIV_ENT, 32'd0);
    cfg_write(CFG_MEM_ENT, 32'd0);
    cfg_write(CFG_ADD_LAT, 32'd1);
    cfg_write(CFG_DIV_LAT, 32'd4);
    run_random(60);
    drain();

    // Shared station with no entries, then oversized.
    cfg_write(CFG_UNIFIED_MODE, 32'd1);
    cfg_write(CFG_UNIFIED_ENT, 32'd0);
    run_random(20);
    drain();
    cfg_write(CFG_UNIFIED_ENT, 32'd31);
    cfg_write(CFG_MEM_LAT, 32'd7);
    run_random(120);
    drain();

    if (sched_sb.mismatches == 0 && sched_sb.pending_results.size() == 0)
      $display("PASS tomasulo_issue_wakeup_scheduler");
    else
      $display("FAIL tomasulo_issue_wakeup_scheduler");
    $finish;
  end
endmodule

// ===== files.f =====
sv/tsch_pkg.sv
sv/tsch_alias.sv
sv/tsch_station.sv
sv/tomasulo_issue_wakeup_scheduler.sv
test/tb_tomasulo_issue_wakeup_scheduler.sv
